>>> rtl/tmnlc_pkg.sv
// Package for the two-means noise level clustering core.
// Holds widths, limits and the sequencer state type; no dependencies.
`default_nettype none
package tmnlc_pkg;
	localparam int MaxScores = 1024;
	localparam int AddrW = 10;
	localparam int CntW = 11;
	localparam int ScoreW = 24;
	localparam int AccW = 34;
	localparam int MaxRounds = 30;
	localparam int RoundW = 5;
	localparam logic [7:0] RatioLimit = 8'd125;

	typedef enum logic [11:0] {
		ST_LOAD  = 12'b000000000001,
		ST_SORTR = 12'b000000000010,
		ST_SORTC = 12'b000000000100,
		ST_SEED0 = 12'b000000001000,
		ST_SEED1 = 12'b000000010000,
		ST_SEED2 = 12'b000000100000,
		ST_PASS  = 12'b000001000000,
		ST_DIVL  = 12'b000010000000,
		ST_DIVH  = 12'b000100000000,
		ST_UPD   = 12'b001000000000,
		ST_FIN   = 12'b010000000000,
		ST_OUT   = 12'b100000000000
	} state_t;

	typedef struct packed {
		logic start;
		logic [AccW-1:0] dividend;
		logic [CntW-1:0] divisor;
	} div_req_t;
endpackage
`default_nettype wire

>>> rtl/two_means_noise_level_clustering_core.sv
// Two-means noise level clustering core; uses tmnlc_pkg and tmnlc_div.
// Load: one item per cycle while in ST_LOAD (input stalled otherwise). On the last item:
// insertion sort (worst n*(n-1)/2 shifts), seeding from entries n/4 and 3n/4, then up to
// 30 rounds of a pass over the scores, two divisions (low and high mean) on the shared
// serial divider, and one update.
// Result registered in ST_FIN after the last round; next item taken the cycle after the result
// is accepted. arst_n clears control state and sets the ratio register to 26.
`default_nettype none
module two_means_noise_level_clustering_core import tmnlc_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic [7:0] cfg_wdata,
	input wire logic in_valid,
	output logic in_stall,
	input wire logic [23:0] score,
	input wire logic score_valid,
	input wire logic last_score,
	output logic out_valid,
	input wire logic out_stall,
	output logic [23:0] center_low,
	output logic [23:0] center_high,
	output logic [23:0] enter_threshold,
	output logic [23:0] exit_threshold,
	output logic centers_valid,
	output logic thresholds_valid
);
	state_t st_q;
	logic [7:0] ratio_q;
	logic [CntW-1:0] n_q;
	logic [CntW-1:0] i_q;      // sort outer index / pass index
	logic [CntW-1:0] j_q;      // sort inner index
	logic [ScoreW-1:0] v_q;    // value being inserted
	logic [ScoreW-1:0] lo_q, hi_q;
	logic [AccW-1:0] lacc_q, hacc_q;
	logic [CntW-1:0] lc_q, hc_q;
	logic [RoundW-1:0] rnd_q;
	logic [ScoreW-1:0] nl_q;
	logic rd_pend_q;

	// score memory: one write, one registered read
	logic [ScoreW-1:0] mem [MaxScores];
	logic [ScoreW-1:0] rd_q;
	logic we;
	logic [AddrW-1:0] wa, ra;
	logic [ScoreW-1:0] wd;

	always_ff @(posedge clk) begin
		if (we) mem[wa] <= wd;
		rd_q <= mem[ra];
	end

	div_req_t dreq;
	logic dbusy;
	logic [ScoreW-1:0] dq;
	tmnlc_div u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .busy(dbusy), .quot(dq));

	logic acc_in;
	assign acc_in = in_valid && !in_stall;
	assign in_stall = (st_q != ST_LOAD);

	// store this item's score when it is valid and there is room
	logic stored;
	logic [CntW-1:0] n_next;
	assign stored = score_valid && (n_q < CntW'(MaxScores));
	assign n_next = n_q + CntW'(stored);

	// insertion step: move the left neighbor up while it is larger
	logic sort_shift;
	assign sort_shift = (j_q != '0) && (rd_q > v_q);

	// distance compare for the pass
	logic [ScoreW-1:0] dl, dh;
	assign dl = (rd_q >= lo_q) ? rd_q - lo_q : lo_q - rd_q;
	assign dh = (rd_q >= hi_q) ? rd_q - hi_q : hi_q - rd_q;

	logic [CntW+1:0] n3;
	assign n3 = {1'b0, n_q, 1'b0} + {2'b0, n_q};

	always_comb begin
		we = 1'b0;
		wa = AddrW'(n_q);
		wd = score;
		ra = AddrW'(i_q);
		dreq = '{start: 1'b0, dividend: lacc_q, divisor: lc_q};
		case (st_q)
			ST_LOAD: begin
				we = acc_in && stored;
			end
			// read entry i first, then its left neighbor
			ST_SORTR: ra = rd_pend_q ? AddrW'(i_q) : AddrW'(i_q - CntW'(1));
			ST_SORTC: begin
				wa = AddrW'(j_q);
				wd = sort_shift ? rd_q : v_q;
				we = 1'b1;
				ra = AddrW'(j_q - CntW'(2));
			end
			ST_SEED0: ra = AddrW'(n_q >> 2);
			ST_SEED1: ra = AddrW'(n3 >> 2);
			ST_SEED2: ra = '0;
			ST_DIVL: dreq = '{start: !dbusy && !rd_pend_q, dividend: lacc_q,
				divisor: lc_q};
			ST_DIVH: dreq = '{start: !dbusy && !rd_pend_q, dividend: hacc_q,
				divisor: hc_q};
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_LOAD;
			ratio_q <= 8'd26;
			n_q <= '0;
			out_valid <= 1'b0;
			rd_pend_q <= 1'b0;
			i_q <= '0;
			j_q <= '0;
			lo_q <= '0;
			hi_q <= '0;
			lacc_q <= '0;
			hacc_q <= '0;
			lc_q <= '0;
			hc_q <= '0;
			rnd_q <= '0;
			nl_q <= '0;
		end else begin
			if (cfg_we) ratio_q <= cfg_wdata;
			case (st_q)
				ST_LOAD: begin
					if (acc_in) begin
						if (stored) n_q <= n_next;
						if (last_score) begin
							i_q <= CntW'(1);
							rd_pend_q <= 1'b1;
							if (n_next >= CntW'(2)) begin
								st_q <= ST_SORTR;
							end else if (stored) begin
								// single score, carried by this item
								lo_q <= score; hi_q <= score;
								st_q <= ST_FIN;
							end else if (n_q == CntW'(1)) begin
								st_q <= ST_SEED2; // single stored score: read it
							end else begin
								st_q <= ST_FIN;
							end
						end
					end
				end
				ST_SORTR: begin
					// first cycle reads entry i, second holds it as the insert value
					if (rd_pend_q) begin
						rd_pend_q <= 1'b0;
					end else if (i_q >= n_q) begin
						st_q <= ST_SEED0;
						rd_pend_q <= 1'b1;
					end else begin
						st_q <= ST_SORTC;
						j_q <= i_q;
					end
				end
				ST_SORTC: begin
					if (sort_shift) begin
						j_q <= j_q - CntW'(1); // shift and keep walking left
					end else begin
						i_q <= i_q + CntW'(1);
						st_q <= ST_SORTR;
						rd_pend_q <= 1'b1;
					end
				end
				ST_SEED0: begin
					if (rd_pend_q) rd_pend_q <= 1'b0;
					else begin lo_q <= rd_q; st_q <= ST_SEED1; rd_pend_q <= 1'b1; end
				end
				ST_SEED1: begin
					if (rd_pend_q) begin
						rd_pend_q <= 1'b0;
					end else begin
						hi_q <= rd_q; st_q <= ST_PASS; rnd_q <= '0;
						i_q <= '0; rd_pend_q <= 1'b1;
						lacc_q <= '0; hacc_q <= '0; lc_q <= '0; hc_q <= '0;
					end
				end
				ST_SEED2: begin
					// single score path: entry 0
					if (rd_pend_q) rd_pend_q <= 1'b0;
					else begin lo_q <= rd_q; hi_q <= rd_q; st_q <= ST_FIN; end
				end
				ST_PASS: begin
					if (rd_pend_q) begin
						rd_pend_q <= 1'b0;
						i_q <= i_q + CntW'(1);
					end else begin
						if (dl <= dh) begin
							lacc_q <= lacc_q + AccW'(rd_q); lc_q <= lc_q + CntW'(1);
						end else begin
							hacc_q <= hacc_q + AccW'(rd_q); hc_q <= hc_q + CntW'(1);
						end
						if (i_q >= n_q) begin
							st_q <= ST_DIVL; rd_pend_q <= 1'b0;
						end else i_q <= i_q + CntW'(1);
					end
				end
				ST_DIVL: begin
					if (lc_q == '0 || hc_q == '0) st_q <= ST_FIN;
					else if (dreq.start) rd_pend_q <= 1'b1;
					else if (rd_pend_q && !dbusy) begin
						nl_q <= dq; rd_pend_q <= 1'b0; st_q <= ST_DIVH;
					end
				end
				ST_DIVH: begin
					if (dreq.start) rd_pend_q <= 1'b1;
					else if (rd_pend_q && !dbusy) begin
						rd_pend_q <= 1'b0;
						hi_q <= dq; lo_q <= nl_q;
						// stop once neither center moves
						st_q <= (nl_q == lo_q && dq == hi_q) ? ST_FIN : ST_UPD;
					end
				end
				ST_UPD: begin
					if (rnd_q == RoundW'(MaxRounds - 1)) st_q <= ST_FIN;
					else begin
						rnd_q <= rnd_q + RoundW'(1); st_q <= ST_PASS; i_q <= '0;
						rd_pend_q <= 1'b1;
						lacc_q <= '0; hacc_q <= '0; lc_q <= '0; hc_q <= '0;
					end
				end
				ST_FIN: begin
					st_q <= ST_OUT;
					out_valid <= 1'b1;
					n_q <= '0;
				end
				ST_OUT: begin
					if (!out_stall) begin out_valid <= 1'b0; st_q <= ST_LOAD; end
				end
				default: st_q <= ST_LOAD;
			endcase
		end
	end

	// insert value capture: entry i arrives on the second SORTR cycle
	always_ff @(posedge clk) begin
		if (st_q == ST_SORTR && !rd_pend_q) v_q <= rd_q;
	end

	// result registers, filled in ST_FIN
	logic [ScoreW-1:0] l2, h2, span;
	logic [7:0] r;
	logic [ScoreW:0] msum;
	logic [ScoreW+7:0] prod;
	assign l2 = (lo_q > hi_q) ? hi_q : lo_q;
	assign h2 = (lo_q > hi_q) ? lo_q : hi_q;
	assign span = h2 - l2;
	assign r = (ratio_q > RatioLimit) ? RatioLimit : ratio_q;
	assign msum = {1'b0, l2} + {1'b0, h2};
	assign prod = (ScoreW+8)'(span) * (ScoreW+8)'(r);
	logic cv_n;
	assign cv_n = (n_q != '0);

	always_ff @(posedge clk) begin
		if (st_q == ST_FIN) begin
			centers_valid <= cv_n;
			center_low <= cv_n ? l2 : '0;
			center_high <= cv_n ? h2 : '0;
			thresholds_valid <= cv_n && (h2 > l2);
			enter_threshold <= (cv_n && h2 > l2) ?
				msum[ScoreW:1] + prod[ScoreW+7:8] : '0;
			exit_threshold <= (cv_n && h2 > l2) ?
				msum[ScoreW:1] - prod[ScoreW+7:8] : '0;
		end
	end
endmodule
`default_nettype wire

>>> rtl/tmnlc_div.sv
// Restoring divider, one quotient bit a cycle, 34-bit by 11-bit.
// Depends on tmnlc_pkg.
`default_nettype none
module tmnlc_div import tmnlc_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire div_req_t req,
	output logic busy,
	output logic [ScoreW-1:0] quot
);
	logic [AccW-1:0] q_q;
	logic [CntW-1:0] rem_q;
	logic [CntW-1:0] dvs_q;
	logic [5:0] cnt_q;
	logic [CntW:0] trial;
	logic [CntW:0] diff;

	always_comb begin
		trial = {rem_q, q_q[AccW-1]};
		diff = trial - {1'b0, dvs_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (req.start) begin
			cnt_q <= 6'(AccW);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 6'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			q_q <= req.dividend;
			rem_q <= '0;
			dvs_q <= req.divisor;
		end else if (cnt_q != '0) begin
			// shift one dividend bit in, subtract when it fits
			if (trial >= {1'b0, dvs_q}) begin
				rem_q <= diff[CntW-1:0];
				q_q <= {q_q[AccW-2:0], 1'b1};
			end else begin
				rem_q <= trial[CntW-1:0];
				q_q <= {q_q[AccW-2:0], 1'b0};
			end
		end
	end

	assign busy = (cnt_q != '0);
	assign quot = q_q[ScoreW-1:0];
endmodule
`default_nettype wire

>>> rtl/tmnlc_checker.sv
// Port-level checker for the clustering core, bound to the top level.
// Needs no package; attaches to the core by the bind at the end.
`default_nettype none
module tmnlc_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_stall,
	input wire logic out_valid,
	input wire logic out_stall,
	input wire logic centers_valid,
	input wire logic thresholds_valid,
	input wire logic [23:0] center_low,
	input wire logic [23:0] center_high
);
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall) else $error("input taken while result pending");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid) else $error("result dropped");
	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> center_low <= center_high) else $error("centers out of order");
	a_tv: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && thresholds_valid |-> centers_valid) else $error("bad flags");
endmodule

bind two_means_noise_level_clustering_core tmnlc_checker u_chk (
	.clk(clk), .arst_n(arst_n), .in_stall(in_stall), .out_valid(out_valid),
	.out_stall(out_stall), .centers_valid(centers_valid),
	.thresholds_valid(thresholds_valid), .center_low(center_low),
	.center_high(center_high));
`default_nettype wire

>>> test/two_means_noise_level_clustering_core_tb.sv
// Testbench for the two-means noise level clustering core.
// Drives sets of noise scores through the valid/stall input, predicts cluster
// centers and hysteresis thresholds on its own, checks each result; uses tmnlc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module two_means_noise_level_clustering_core_tb;
	import tmnlc_pkg::*;

	localparam int CycleLimit = 4000000;

	typedef struct {
		logic [23:0] lo_c;
		logic [23:0] hi_c;
		logic [23:0] enter_t;
		logic [23:0] exit_t;
		logic        c_ok;
		logic        t_ok;
	} clusters_t;

	// Noise clustering predictor: holds the open set, the means and the ratio.
	class cluster_board;
		logic [23:0] set_scores[$];
		logic [31:0] lo_mean, hi_mean;
		logic [7:0]  ratio;
		clusters_t   pending[$];
		int          errors, results, sets_closed;

		function new();
			lo_mean = 0;
			hi_mean = 0;
			ratio = 8'd26;
		endfunction

		function void run_two_means();
			int unsigned n;
			logic [31:0] nl, nh, s, dl, dh;
			logic [63:0] la, ha;
			int unsigned lc, hc;
			n = set_scores.size();
			set_scores.sort();
			lo_mean = 32'(set_scores[n / 4]);
			hi_mean = 32'(set_scores[(3 * n) / 4]);
			for (int r = 0; r < MaxRounds; r++) begin
				la = 0; ha = 0; lc = 0; hc = 0;
				foreach (set_scores[i]) begin
					s = 32'(set_scores[i]);
					dl = (s >= lo_mean) ? s - lo_mean : lo_mean - s;
					dh = (s >= hi_mean) ? s - hi_mean : hi_mean - s;
					// equal distance joins the low cluster
					if (dl <= dh) begin
						la += 64'(s); lc++;
					end else begin
						ha += 64'(s); hc++;
					end
				end
				if (lc == 0 || hc == 0) break;
				nl = 32'(la / 64'(lc));
				nh = 32'(ha / 64'(hc));
				if (nl == lo_mean && nh == hi_mean) break;
				lo_mean = nl;
				hi_mean = nh;
			end
			if (lo_mean > hi_mean) begin
				nl = lo_mean; lo_mean = hi_mean; hi_mean = nl;
			end
		endfunction

		// Note one accepted item; a closing item queues the expected clusters.
		function void note_score(logic [23:0] sc, logic sv, logic last);
			clusters_t e;
			logic [31:0] r, mid, hyst;
			if (sv && set_scores.size() < MaxScores)
				set_scores.insert(set_scores.size(), sc);
			if (!last) return;
			e = '{default: '0};
			if (set_scores.size() == 1) begin
				lo_mean = 32'(set_scores[0]);
				hi_mean = 32'(set_scores[0]);
			end else if (set_scores.size() >= 2) begin
				run_two_means();
			end
			if (set_scores.size() >= 1) begin
				e.c_ok = 1'b1;
				e.lo_c = lo_mean[23:0];
				e.hi_c = hi_mean[23:0];
				if (hi_mean > lo_mean) begin
					r = 32'((ratio > RatioLimit) ? RatioLimit : ratio);
					mid = 32'(({32'd0, lo_mean} + {32'd0, hi_mean}) >> 1);
					hyst = (r * (hi_mean - lo_mean)) >> 8;
					e.t_ok = 1'b1;
					e.enter_t = 24'(mid + hyst);
					e.exit_t = 24'(mid - hyst);
				end
			end
			set_scores.delete();
			sets_closed++;
			pending.insert(pending.size(), e);
		endfunction

		function void check_clusters(clusters_t a);
			clusters_t e;
			results++;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result lo=%h hi=%h", $time, a.lo_c, a.hi_c);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (a.lo_c !== e.lo_c) begin
				$display("%0t: center_low exp %h got %h", $time, e.lo_c, a.lo_c); errors++;
			end
			if (a.hi_c !== e.hi_c) begin
				$display("%0t: center_high exp %h got %h", $time, e.hi_c, a.hi_c); errors++;
			end
			if (a.enter_t !== e.enter_t) begin
				$display("%0t: enter_threshold exp %h got %h", $time, e.enter_t, a.enter_t);
				errors++;
			end
			if (a.exit_t !== e.exit_t) begin
				$display("%0t: exit_threshold exp %h got %h", $time, e.exit_t, a.exit_t);
				errors++;
			end
			if (a.c_ok !== e.c_ok) begin
				$display("%0t: centers_valid exp %b got %b", $time, e.c_ok, a.c_ok); errors++;
			end
			if (a.t_ok !== e.t_ok) begin
				$display("%0t: thresholds_valid exp %b got %b", $time, e.t_ok, a.t_ok);
				errors++;
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_we = 0;
	logic [7:0] cfg_wdata = 0;
	logic in_valid = 0;
	logic in_stall;
	logic [23:0] score = 0;
	logic score_valid = 0;
	logic last_score = 0;
	logic out_valid;
	logic out_stall = 0;
	logic [23:0] center_low, center_high, enter_threshold, exit_threshold;
	logic centers_valid, thresholds_valid;

	cluster_board board = new();
	bit steady = 0;  // when set, neither side idles
	int cycles = 0;
	int items_sent = 0;

	two_means_noise_level_clustering_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.score(score),
		.score_valid(score_valid),
		.last_score(last_score),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.center_low(center_low),
		.center_high(center_high),
		.enter_threshold(enter_threshold),
		.exit_threshold(exit_threshold),
		.centers_valid(centers_valid),
		.thresholds_valid(thresholds_valid)
	);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	// Result side: stall at random, check every accepted result.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			board.check_clusters('{center_low, center_high, enter_threshold,
				exit_threshold, centers_valid, thresholds_valid});
		out_stall <= steady ? 1'b0 : ($urandom_range(99) < 26);
	end

	// Hard stop in case the block hangs.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CycleLimit) begin
			$display("timeout after %0d cycles", cycles);
			$display("FAIL two_means_noise_level_clustering_core");
			$finish;
		end
	end

	// Offer one item and hold it until the block takes it.
	task automatic push_score(logic [23:0] sc, logic sv, logic last);
		while (!steady && $urandom_range(99) < 26) begin
			in_valid <= 0;
			@(posedge clk);
		end
		score <= sc;
		score_valid <= sv;
		last_score <= last;
		in_valid <= 1;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		board.note_score(sc, sv, last);
		items_sent++;
	endtask

	// Drain outstanding results, let the block settle, then write the ratio.
	task automatic set_ratio(logic [7:0] v);
		in_valid <= 0;
		@(posedge clk);
		while (board.pending.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		cfg_we <= 1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 0;
		board.ratio = v;
	endtask

	// Draw a score: full range, near one of two random levels, or near either end of the range.
	function automatic logic [23:0] draw_score(int shape, logic [23:0] a, logic [23:0] b);
		int unsigned j;
		j = $urandom_range(4095);
		case (shape)
			0: draw_score = 24'($urandom);
			1: draw_score = 24'(32'($urandom_range(1) ? a : b) ^ j);
			default: draw_score = $urandom_range(3) == 0 ? 24'(32'hFFFFFF - j) : 24'(j);
		endcase
	endfunction

	// Send one set of n items; the last one closes it.
	task automatic send_set(int n);
		int shape;
		logic [23:0] a, b;
		shape = $urandom_range(2);
		a = 24'($urandom);
		b = 24'($urandom);
		for (int i = 0; i < n; i++)
			push_score(draw_score(shape, a, b), $urandom_range(99) < 85, i == n - 1);
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed: empty set, single score, extremes, ties, skipped scores.
		push_score(24'h123456, 0, 1);
		push_score(24'hFFFFFF, 1, 1);
		push_score(24'h000000, 1, 1);
		push_score(24'h000000, 1, 0);
		push_score(24'hFFFFFF, 1, 1);
		push_score(24'h400000, 1, 0);
		push_score(24'h400000, 1, 1);
		push_score(24'h000010, 1, 0);
		push_score(24'h000030, 1, 0);
		push_score(24'h000020, 1, 0);
		push_score(24'hABCDEF, 0, 0);
		push_score(24'h800000, 1, 0);
		push_score(24'h800020, 1, 1);
		set_ratio(8'd0);
		push_score(24'h000000, 1, 0);
		push_score(24'hFFFFFF, 1, 1);
		set_ratio(8'd255);
		push_score(24'h000000, 1, 0);
		push_score(24'h555555, 0, 0);
		push_score(24'hFFFFFF, 1, 1);
		set_ratio(8'd125);
		push_score(24'h000100, 1, 0);
		push_score(24'hF00000, 1, 1);
		set_ratio(8'd126);
		push_score(24'h000100, 1, 0);
		push_score(24'hF00000, 1, 1);

		// Long set with no idling; ascending order keeps the sort short.
		steady = 1;
		for (int i = 0; i < 300; i++)
			push_score(24'(i * 50000 + int'($urandom_range(15))), 1, i == 299);
		steady = 0;

		// Random sets, mostly small, with the odd larger one.
		while (items_sent < 850) begin
			if ($urandom_range(9) == 0) set_ratio(8'($urandom));
			if ($urandom_range(29) == 0) send_set($urandom_range(100, 160));
			else send_set($urandom_range(1, 12));
			if ($urandom_range(19) == 0) steady = !steady;
		end
		steady = 0;
		in_valid <= 0;
		@(posedge clk);

		while (board.pending.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		$display("covered %0d items in %0d sets, %0d results checked, %0d cycles",
			items_sent, board.sets_closed, board.results, cycles);
		if (board.errors == 0) begin
			$display("PASS two_means_noise_level_clustering_core");
		end else begin
			$display("%0d mismatches", board.errors);
			$display("FAIL two_means_noise_level_clustering_core");
		end
		$finish;
	end
endmodule
`default_nettype wire
